>>> rtl/core/stk_pkg.sv
// Shared constants for the source tokenizer: token class codes, bundle sizing
// and byte classification functions. No dependencies.
`default_nettype none

package stk_pkg;

	localparam int CLASS_BITS = 6;
	localparam int MAX_TOK = 3;
	localparam int CNT_BITS = 2;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic [CLASS_BITS-1:0] class_t;

	localparam class_t CL_LBRACE   = 6'd0;
	localparam class_t CL_RBRACE   = 6'd1;
	localparam class_t CL_LBRACKET = 6'd2;
	localparam class_t CL_RBRACKET = 6'd3;
	localparam class_t CL_LPAREN   = 6'd4;
	localparam class_t CL_RPAREN   = 6'd5;
	localparam class_t CL_QUEST    = 6'd6;
	localparam class_t CL_COLON    = 6'd7;
	localparam class_t CL_SEMI     = 6'd8;
	localparam class_t CL_COMMA    = 6'd9;
	localparam class_t CL_DOT      = 6'd10;
	localparam class_t CL_CARET    = 6'd11;
	localparam class_t CL_PIPEPIPE = 6'd12;
	localparam class_t CL_AMPAMP   = 6'd13;
	localparam class_t CL_STAR_EQ  = 6'd14;
	localparam class_t CL_STAR     = 6'd15;
	localparam class_t CL_PLUS_EQ  = 6'd16;
	localparam class_t CL_PLUS     = 6'd17;
	localparam class_t CL_MINUS_EQ = 6'd18;
	localparam class_t CL_MINUS    = 6'd19;
	localparam class_t CL_SLASH_EQ = 6'd20;
	localparam class_t CL_SLASH    = 6'd21;
	localparam class_t CL_BANG_EQ  = 6'd22;
	localparam class_t CL_BANG     = 6'd23;
	localparam class_t CL_LE       = 6'd24;
	localparam class_t CL_LT       = 6'd25;
	localparam class_t CL_GE       = 6'd26;
	localparam class_t CL_GT       = 6'd27;
	localparam class_t CL_EQEQ     = 6'd28;
	localparam class_t CL_ASSIGN   = 6'd29;
	localparam class_t CL_STRING   = 6'd30;
	localparam class_t CL_IDENT    = 6'd31;
	localparam class_t CL_NUMBER   = 6'd32;
	localparam class_t CL_UNKNOWN  = 6'd33;
	localparam class_t CL_END      = 6'd34;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	endfunction

	// {hit, class} for single-character punctuation
	function automatic logic [CLASS_BITS:0] punct_class(input logic [7:0] b);
		logic [CLASS_BITS:0] r;
		case (b)
			"{": r = {1'b1, CL_LBRACE};
			"}": r = {1'b1, CL_RBRACE};
			"[": r = {1'b1, CL_LBRACKET};
			"]": r = {1'b1, CL_RBRACKET};
			"(": r = {1'b1, CL_LPAREN};
			")": r = {1'b1, CL_RPAREN};
			"?": r = {1'b1, CL_QUEST};
			":": r = {1'b1, CL_COLON};
			";": r = {1'b1, CL_SEMI};
			",": r = {1'b1, CL_COMMA};
			"^": r = {1'b1, CL_CARET};
			default: r = {1'b0, CL_UNKNOWN};
		endcase
		return r;
	endfunction

	// {hit, class} for an operator that may take a trailing '='
	function automatic logic [CLASS_BITS:0] eq_single(input logic [7:0] b);
		logic [CLASS_BITS:0] r;
		case (b)
			"*": r = {1'b1, CL_STAR};
			"+": r = {1'b1, CL_PLUS};
			"-": r = {1'b1, CL_MINUS};
			"/": r = {1'b1, CL_SLASH};
			"!": r = {1'b1, CL_BANG};
			"<": r = {1'b1, CL_LT};
			">": r = {1'b1, CL_GT};
			"=": r = {1'b1, CL_ASSIGN};
			default: r = {1'b0, CL_UNKNOWN};
		endcase
		return r;
	endfunction

	function automatic class_t eq_double(input logic [7:0] b);
		class_t r;
		case (b)
			"*": r = CL_STAR_EQ;
			"+": r = CL_PLUS_EQ;
			"-": r = CL_MINUS_EQ;
			"/": r = CL_SLASH_EQ;
			"!": r = CL_BANG_EQ;
			"<": r = CL_LE;
			">": r = CL_GE;
			"=": r = CL_EQEQ;
			default: r = CL_UNKNOWN;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/stk_front.sv
// Tokenizer front: lexer mode machine taking one byte per cycle while take is
// high and packing the tokens it finishes into one bundle. Depends on stk_pkg.
`default_nettype none

module stk_front #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = stk_pkg::LENGTH_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  wire logic [7:0] char_byte,
	output logic wr_en,
	output logic [stk_pkg::CNT_BITS +
		stk_pkg::MAX_TOK*(stk_pkg::CLASS_BITS+OFFSET_BITS+LENGTH_BITS)-1:0] wr_data
);
	import stk_pkg::*;

	localparam int TOK_W = CLASS_BITS + OFFSET_BITS + LENGTH_BITS;
	localparam int WIDE = (OFFSET_BITS + 1 > LENGTH_BITS) ? OFFSET_BITS + 1 : LENGTH_BITS;
	localparam logic [WIDE-1:0] LEN_MAX_W = {{(WIDE-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

	typedef enum logic [7:0] {
		M_IDLE    = 8'b0000_0001,
		M_OP      = 8'b0000_0010,
		M_DOT     = 8'b0000_0100,
		M_STRING  = 8'b0000_1000,
		M_IDENT   = 8'b0001_0000,
		M_MANT    = 8'b0010_0000,
		M_EXPCHAR = 8'b0100_0000,
		M_EXP     = 8'b1000_0000
	} mode_t;

	function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [OFFSET_BITS:0] v);
		logic [WIDE-1:0] w;
		w = WIDE'(v);
		if (w > LEN_MAX_W)
			return LEN_MAX_W[LENGTH_BITS-1:0];
		return w[LENGTH_BITS-1:0];
	endfunction

	mode_t mode_q, mode_d;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] begin_q, begin_d;
	logic [7:0] first_q, first_d;
	logic period_q, period_d;
	logic bad_q, bad_d;

	logic [OFFSET_BITS-1:0] cur;
	logic [OFFSET_BITS-1:0] eoff;
	logic [OFFSET_BITS:0] span;
	logic [OFFSET_BITS:0] span_inc;
	logic [CLASS_BITS:0] punct_hit;
	logic [CLASS_BITS:0] single_hit;
	logic [CLASS_BITS:0] first_single;
	class_t num_cls;
	logic alnum;
	logic restart;
	logic [CNT_BITS-1:0] n;
	logic [MAX_TOK-1:0][CLASS_BITS-1:0] cls_v;
	logic [MAX_TOK-1:0][OFFSET_BITS-1:0] start_v;
	logic [MAX_TOK-1:0][LENGTH_BITS-1:0] len_v;
	logic [MAX_TOK-1:0][TOK_W-1:0] tok_v;

	assign cur = offset_q;
	assign span = {1'b0, cur - begin_q};
	assign span_inc = span + (OFFSET_BITS+1)'(1);
	assign eoff = (cur > begin_q) ? cur - OFFSET_BITS'(1) : begin_q;
	assign punct_hit = punct_class(char_byte);
	assign single_hit = eq_single(char_byte);
	assign first_single = eq_single(first_q);
	assign num_cls = bad_q ? CL_UNKNOWN : CL_NUMBER;
	assign alnum = is_alpha(char_byte) || is_digit(char_byte);

	always_comb begin
		mode_d = mode_q;
		begin_d = begin_q;
		first_d = first_q;
		period_d = period_q;
		bad_d = bad_q;
		restart = 1'b0;
		n = '0;
		cls_v = '0;
		start_v = '0;
		len_v = '0;

		case (mode_q)
			M_OP: begin
				if ((first_q == "|") || (first_q == "&")) begin
					mode_d = M_IDLE;
					if (char_byte == first_q) begin
						cls_v[n] = (first_q == "|") ? CL_PIPEPIPE : CL_AMPAMP;
						start_v[n] = begin_q;
						len_v[n] = sat_len(span_inc);
						n = n + CNT_BITS'(1);
					end else if (char_byte == 8'h00) begin
						cls_v[n] = CL_UNKNOWN;
						start_v[n] = begin_q;
						len_v[n] = sat_len(span);
						n = n + CNT_BITS'(1);
						cls_v[n] = CL_END;
						start_v[n] = cur;
						len_v[n] = LEN_ONE;
						n = n + CNT_BITS'(1);
					end else begin
						cls_v[n] = CL_UNKNOWN;
						start_v[n] = begin_q;
						len_v[n] = sat_len(span_inc);
						n = n + CNT_BITS'(1);
					end
				end else if (char_byte == "=") begin
					mode_d = M_IDLE;
					cls_v[n] = eq_double(first_q);
					start_v[n] = begin_q;
					len_v[n] = sat_len(span_inc);
					n = n + CNT_BITS'(1);
				end else begin
					cls_v[n] = first_single[CLASS_BITS-1:0];
					start_v[n] = begin_q;
					len_v[n] = sat_len(span);
					n = n + CNT_BITS'(1);
					restart = 1'b1;
				end
			end
			M_DOT: begin
				if (is_digit(char_byte)) begin
					period_d = 1'b1;
					bad_d = 1'b0;
					mode_d = M_MANT;
				end else begin
					cls_v[n] = CL_DOT;
					start_v[n] = begin_q;
					len_v[n] = sat_len(span);
					n = n + CNT_BITS'(1);
					restart = 1'b1;
				end
			end
			M_STRING: begin
				if (char_byte == "\"") begin
					mode_d = M_IDLE;
					cls_v[n] = CL_STRING;
					start_v[n] = begin_q;
					len_v[n] = sat_len(span_inc);
					n = n + CNT_BITS'(1);
				end else if (char_byte == 8'h00) begin
					mode_d = M_IDLE;
					cls_v[n] = CL_UNKNOWN;
					start_v[n] = begin_q;
					len_v[n] = sat_len(span);
					n = n + CNT_BITS'(1);
					cls_v[n] = CL_END;
					start_v[n] = cur;
					len_v[n] = LEN_ONE;
					n = n + CNT_BITS'(1);
				end
			end
			M_IDENT: begin
				if (!alnum) begin
					cls_v[n] = CL_IDENT;
					start_v[n] = begin_q;
					len_v[n] = sat_len(span);
					n = n + CNT_BITS'(1);
					restart = 1'b1;
				end
			end
			M_MANT, M_EXP: begin
				if (is_digit(char_byte)) begin
					mode_d = mode_q;
				end else if (char_byte == ".") begin
					if (period_q)
						bad_d = 1'b1;
					else
						period_d = 1'b1;
				end else if ((mode_q == M_MANT) && ((char_byte == "e") || (char_byte == "E"))) begin
					mode_d = M_EXPCHAR;
				end else begin
					cls_v[n] = num_cls;
					start_v[n] = begin_q;
					len_v[n] = sat_len(span);
					n = n + CNT_BITS'(1);
					restart = 1'b1;
				end
			end
			M_EXPCHAR: begin
				if ((char_byte == "+") || (char_byte == "-")) begin
					period_d = 1'b0;
					mode_d = M_EXP;
				end else begin
					// number ends before the letter; the letter opens an identifier
					cls_v[n] = num_cls;
					start_v[n] = begin_q;
					len_v[n] = sat_len({1'b0, eoff - begin_q});
					n = n + CNT_BITS'(1);
					begin_d = eoff;
					mode_d = M_IDENT;
					if (!alnum) begin
						cls_v[n] = CL_IDENT;
						start_v[n] = eoff;
						len_v[n] = sat_len({1'b0, cur - eoff});
						n = n + CNT_BITS'(1);
						restart = 1'b1;
					end
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		if (restart) begin
			mode_d = M_IDLE;
			if (is_space(char_byte)) begin
				mode_d = M_IDLE;
			end else if (char_byte == 8'h00) begin
				cls_v[n] = CL_END;
				start_v[n] = cur;
				len_v[n] = LEN_ONE;
				n = n + CNT_BITS'(1);
			end else begin
				begin_d = cur;
				if (char_byte == ".") begin
					mode_d = M_DOT;
				end else if (punct_hit[CLASS_BITS]) begin
					cls_v[n] = punct_hit[CLASS_BITS-1:0];
					start_v[n] = cur;
					len_v[n] = LEN_ONE;
					n = n + CNT_BITS'(1);
				end else if ((char_byte == "|") || (char_byte == "&") || single_hit[CLASS_BITS]) begin
					first_d = char_byte;
					mode_d = M_OP;
				end else if (char_byte == "\"") begin
					mode_d = M_STRING;
				end else if (is_alpha(char_byte)) begin
					mode_d = M_IDENT;
				end else if (is_digit(char_byte)) begin
					period_d = 1'b0;
					bad_d = 1'b0;
					mode_d = M_MANT;
				end else begin
					cls_v[n] = CL_UNKNOWN;
					start_v[n] = cur;
					len_v[n] = LEN_ONE;
					n = n + CNT_BITS'(1);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_TOK; i++) begin
			tok_v[i] = {cls_v[i], start_v[i], len_v[i]};
		end
	end

	assign wr_en = take && (n != '0);
	assign wr_data = {n, tok_v};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			offset_q <= '0;
			begin_q <= '0;
			first_q <= '0;
			period_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			begin_q <= begin_d;
			first_q <= first_d;
			period_q <= period_d;
			bad_q <= bad_d;
			// hold the offset once it saturates
			if (offset_q != '1)
				offset_q <= offset_q + OFFSET_BITS'(1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/stk_queue.sv
// Short bundle queue between the lexer front and the output serializer.
// Depends on stk_pkg for default sizing.
`default_nettype none

module stk_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH = stk_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic q_full,
	output logic q_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W:0] DEPTH_C = (PTR_W+1)'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_C = PTR_W'(DEPTH - 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;
	logic do_wr;
	logic do_rd;

	assign q_full = (count_q == DEPTH_C);
	assign q_empty = (count_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + (PTR_W+1)'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - (PTR_W+1)'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + (PTR_W+1)'(1)))
		else $error("queue count missed a write");

endmodule

`default_nettype wire

>>> rtl/core/stk_back.sv
// Back part of the tokenizer: walks the tokens of the head bundle one per
// pop and flags the last one of each byte. Depends on stk_pkg.
`default_nettype none

module stk_back #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = stk_pkg::LENGTH_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [stk_pkg::CNT_BITS +
		stk_pkg::MAX_TOK*(stk_pkg::CLASS_BITS+OFFSET_BITS+LENGTH_BITS)-1:0] rd_data,
	input  wire logic q_empty,
	input  wire logic pop,
	output logic rd_en,
	output logic empty,
	output logic [stk_pkg::CLASS_BITS-1:0] token_class,
	output logic [OFFSET_BITS-1:0] token_start,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic last_of_run
);
	import stk_pkg::*;

	localparam int TOK_W = CLASS_BITS + OFFSET_BITS + LENGTH_BITS;

	logic [CNT_BITS-1:0] head_cnt;
	logic [MAX_TOK-1:0][TOK_W-1:0] toks;
	logic [TOK_W-1:0] tok_sel;
	logic [CNT_BITS-1:0] idx_q;
	logic take_out;

	assign {head_cnt, toks} = rd_data;
	assign tok_sel = toks[idx_q];
	assign empty = q_empty;
	assign token_class = tok_sel[TOK_W-1 -: CLASS_BITS];
	assign token_start = tok_sel[LENGTH_BITS +: OFFSET_BITS];
	assign token_length = tok_sel[LENGTH_BITS-1:0];
	assign last_of_run = (idx_q == head_cnt - CNT_BITS'(1));
	assign take_out = pop && !q_empty;
	// release the bundle with its final token
	assign rd_en = take_out && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take_out) begin
			idx_q <= last_of_run ? '0 : idx_q + CNT_BITS'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !q_empty |-> (head_cnt != '0))
		else $error("empty bundle in queue");
	assert property (@(posedge clk) disable iff (!arst_n) !q_empty |-> (idx_q < head_cnt))
		else $error("token index past bundle count");
	assert property (@(posedge clk) disable iff (!arst_n) q_empty |-> (idx_q == '0))
		else $error("token index not cleared while idle");
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |=> (idx_q == '0))
		else $error("token index not cleared after bundle release");

endmodule

`default_nettype wire

>>> rtl/core/source_tokenizer_top.sv
// Source tokenizer top level: lexer front, bundle queue and output walker.
// Depends on stk_pkg, stk_front, stk_queue and stk_back.
//
// Usage:
//   Input channel: drive char_byte with push; a byte is taken at a rising edge
//   with push high and full low. A zero byte marks end of stream and yields
//   the end token; the lexer then goes idle and keeps tokenizing.
//   Result channel: while empty is low the oldest token sits on token_class,
//   token_start, token_length and last_of_run; pop high takes it.
//   One byte yields zero to three tokens; last_of_run marks the final one.
//   Throughput: one byte per cycle into the lexer while full is low and one
//   token per cycle out; the front keeps taking bytes while the receiver
//   stalls, until the bundle queue of QUEUE_DEPTH entries fills, then full
//   rises.
//   Reset (arst_n low) empties the queue, sets the byte offset to zero and
//   puts the lexer between tokens. Offsets and lengths saturate.
`default_nettype none

module source_tokenizer_top #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = stk_pkg::LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = stk_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [7:0] char_byte,
	output logic empty,
	input  wire logic pop,
	output logic [stk_pkg::CLASS_BITS-1:0] token_class,
	output logic [OFFSET_BITS-1:0] token_start,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic last_of_run
);
	import stk_pkg::*;

	localparam int BUNDLE_W = CNT_BITS + MAX_TOK*(CLASS_BITS + OFFSET_BITS + LENGTH_BITS);

	logic take;
	logic wr_en;
	logic [BUNDLE_W-1:0] wr_data;
	logic rd_en;
	logic [BUNDLE_W-1:0] rd_data;
	logic q_full;
	logic q_empty;

	assign full = q_full;
	assign take = push && !q_full;

	stk_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.char_byte(char_byte),
		.wr_en(wr_en),
		.wr_data(wr_data)
	);

	stk_queue #(
		.DATA_W(BUNDLE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_data(rd_data),
		.q_full(q_full),
		.q_empty(q_empty)
	);

	stk_back #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rd_data(rd_data),
		.q_empty(q_empty),
		.pop(pop),
		.rd_en(rd_en),
		.empty(empty),
		.token_class(token_class),
		.token_start(token_start),
		.token_length(token_length),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire

>>> dv/tokenizer_checker.sv
// Token checker for source_tokenizer_top: watches the byte and token channels,
// predicts the token stream byte by byte and compares every popped token.
// Depends on stk_pkg for the class codes.
module tokenizer_checker #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = stk_pkg::LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic [7:0] char_byte,
	input  logic empty,
	input  logic pop,
	input  logic [stk_pkg::CLASS_BITS-1:0] token_class,
	input  logic [OFFSET_BITS-1:0] token_start,
	input  logic [LENGTH_BITS-1:0] token_length,
	input  logic last_of_run,
	output int mismatches,
	output int outstanding,
	output int tokens_checked,
	output int longest_len
);
	timeunit 1ns;
	timeprecision 1ps;

	import stk_pkg::*;

	localparam longint unsigned OFF_TOP = (64'd1 << OFFSET_BITS) - 64'd1;
	localparam longint unsigned LEN_TOP = (64'd1 << LENGTH_BITS) - 64'd1;

	typedef enum logic [3:0] {
		LX_IDLE, LX_OP, LX_DOT, LX_STR, LX_WORD, LX_MANT, LX_EXPLET, LX_EXP
	} lex_state_t;

	typedef struct packed {
		class_t cls;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] len;
		logic last;
	} token_t;

	lex_state_t lex_state;
	longint unsigned next_off;
	longint unsigned tok_begin;
	logic [7:0] held_op;
	bit dot_seen;
	bit num_broken;

	token_t run_buf[3];
	int run_cnt;
	token_t tokens_due[$];

	function automatic bit digit_c(input logic [7:0] b);
		return b inside {["0":"9"]};
	endfunction

	function automatic bit word_c(input logic [7:0] b);
		return b inside {["a":"z"], ["A":"Z"], "_"};
	endfunction

	// plain operator class for bytes that take a trailing '=', else unknown
	function automatic class_t assign_op_class(input logic [7:0] b);
		case (b)
			"*": return CL_STAR;
			"+": return CL_PLUS;
			"-": return CL_MINUS;
			"/": return CL_SLASH;
			"!": return CL_BANG;
			"<": return CL_LT;
			">": return CL_GT;
			"=": return CL_ASSIGN;
			default: return CL_UNKNOWN;
		endcase
	endfunction

	function automatic void put_token(input class_t c, input longint unsigned s,
			input longint unsigned n);
		if (run_cnt >= 3)
			return;
		if (n > LEN_TOP)
			n = LEN_TOP;
		run_buf[run_cnt].cls = c;
		run_buf[run_cnt].start = s[OFFSET_BITS-1:0];
		run_buf[run_cnt].len = n[LENGTH_BITS-1:0];
		run_buf[run_cnt].last = 1'b0;
		run_cnt++;
	endfunction

	function automatic void begin_token(input logic [7:0] b, input longint unsigned cur);
		lex_state = LX_IDLE;
		if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A)
			return;
		if (b == 8'h00) begin
			put_token(CL_END, cur, 1);
			return;
		end
		tok_begin = cur;
		case (b)
			".": lex_state = LX_DOT;
			"{": put_token(CL_LBRACE, cur, 1);
			"}": put_token(CL_RBRACE, cur, 1);
			"[": put_token(CL_LBRACKET, cur, 1);
			"]": put_token(CL_RBRACKET, cur, 1);
			"(": put_token(CL_LPAREN, cur, 1);
			")": put_token(CL_RPAREN, cur, 1);
			"?": put_token(CL_QUEST, cur, 1);
			":": put_token(CL_COLON, cur, 1);
			";": put_token(CL_SEMI, cur, 1);
			",": put_token(CL_COMMA, cur, 1);
			"^": put_token(CL_CARET, cur, 1);
			"|", "&": begin
				held_op = b;
				lex_state = LX_OP;
			end
			"\"": lex_state = LX_STR;
			default: begin
				if (assign_op_class(b) != CL_UNKNOWN) begin
					held_op = b;
					lex_state = LX_OP;
				end else if (word_c(b)) begin
					lex_state = LX_WORD;
				end else if (digit_c(b)) begin
					dot_seen = 1'b0;
					num_broken = 1'b0;
					lex_state = LX_MANT;
				end else begin
					put_token(CL_UNKNOWN, cur, 1);
				end
			end
		endcase
	endfunction

	function automatic void close_number(input longint unsigned end_excl);
		put_token(num_broken ? CL_UNKNOWN : CL_NUMBER, tok_begin, end_excl - tok_begin);
	endfunction

	// advance the lexer by one byte and queue the tokens it closes
	function automatic void lex_byte(input logic [7:0] b);
		longint unsigned cur;
		longint unsigned eoff;
		class_t single;
		cur = next_off;
		run_cnt = 0;
		case (lex_state)
			LX_OP: begin
				if (held_op == "|" || held_op == "&") begin
					lex_state = LX_IDLE;
					if (b == held_op)
						put_token((held_op == "|") ? CL_PIPEPIPE : CL_AMPAMP,
							tok_begin, cur - tok_begin + 1);
					else if (b == 8'h00) begin
						put_token(CL_UNKNOWN, tok_begin, cur - tok_begin);
						put_token(CL_END, cur, 1);
					end else
						put_token(CL_UNKNOWN, tok_begin, cur - tok_begin + 1);
				end else begin
					single = assign_op_class(held_op);
					if (b == "=") begin
						lex_state = LX_IDLE;
						put_token(single - 1'b1, tok_begin, cur - tok_begin + 1);
					end else begin
						put_token(single, tok_begin, cur - tok_begin);
						begin_token(b, cur);
					end
				end
			end
			LX_DOT: begin
				if (digit_c(b)) begin
					dot_seen = 1'b1;
					num_broken = 1'b0;
					lex_state = LX_MANT;
				end else begin
					put_token(CL_DOT, tok_begin, cur - tok_begin);
					begin_token(b, cur);
				end
			end
			LX_STR: begin
				if (b == "\"") begin
					lex_state = LX_IDLE;
					put_token(CL_STRING, tok_begin, cur - tok_begin + 1);
				end else if (b == 8'h00) begin
					lex_state = LX_IDLE;
					put_token(CL_UNKNOWN, tok_begin, cur - tok_begin);
					put_token(CL_END, cur, 1);
				end
			end
			LX_WORD: begin
				if (!(word_c(b) || digit_c(b))) begin
					put_token(CL_IDENT, tok_begin, cur - tok_begin);
					begin_token(b, cur);
				end
			end
			LX_MANT, LX_EXP: begin
				if (digit_c(b)) begin
				end else if (b == ".") begin
					if (dot_seen)
						num_broken = 1'b1;
					else
						dot_seen = 1'b1;
				end else if (lex_state == LX_MANT && (b == "e" || b == "E")) begin
					lex_state = LX_EXPLET;
				end else begin
					close_number(cur);
					begin_token(b, cur);
				end
			end
			LX_EXPLET: begin
				if (b == "+" || b == "-") begin
					dot_seen = 1'b0;
					lex_state = LX_EXP;
				end else begin
					// the exponent letter falls back to starting a word
					eoff = (cur > tok_begin) ? cur - 1 : tok_begin;
					close_number(eoff);
					tok_begin = eoff;
					lex_state = LX_WORD;
					if (!(word_c(b) || digit_c(b))) begin
						put_token(CL_IDENT, tok_begin, cur - tok_begin);
						begin_token(b, cur);
					end
				end
			end
			default: begin_token(b, cur);
		endcase
		if (next_off < OFF_TOP)
			next_off++;
		if (run_cnt > 0)
			run_buf[run_cnt-1].last = 1'b1;
		for (int i = 0; i < run_cnt; i++)
			tokens_due.insert(tokens_due.size(), run_buf[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t got;
		token_t want;
		if (!arst_n) begin
			lex_state = LX_IDLE;
			next_off = 0;
			tok_begin = 0;
			held_op = 8'h00;
			dot_seen = 1'b0;
			num_broken = 1'b0;
			run_cnt = 0;
			tokens_due.delete();
			mismatches = 0;
			tokens_checked = 0;
			longest_len = 0;
			outstanding <= 0;
		end else begin
			// check the popped token before this edge's byte adds new ones
			if (pop && !empty) begin
				got.cls = token_class;
				got.start = token_start;
				got.len = token_length;
				got.last = last_of_run;
				if (tokens_due.size() == 0) begin
					mismatches++;
					$display({"%0t: unexpected token: expected none, got class %0d",
						" start %0d length %0d"}, $time, got.cls, got.start, got.len);
				end else begin
					want = tokens_due[0];
					tokens_due.delete(0);
					tokens_checked++;
					if (got.len > longest_len)
						longest_len = int'(got.len);
					if (got.cls !== want.cls || got.start !== want.start ||
							got.len !== want.len || got.last !== want.last) begin
						mismatches++;
						$display({"%0t: token mismatch: expected class %0d start %0d",
							" length %0d last %0d, got class %0d start %0d length %0d",
							" last %0d"}, $time, want.cls, want.start, want.len,
							want.last, got.cls, got.start, got.len, got.last);
					end
				end
			end
			if (push && !full)
				lex_byte(char_byte);
			outstanding <= tokens_due.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// Testbench top for source_tokenizer_top: drives source bytes and pops tokens
// with random idling, and reports the verdict from tokenizer_checker.
// Depends on stk_pkg, the tokenizer RTL and dv/tokenizer_checker.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stk_pkg::*;

	localparam int RANDOM_BYTES = 110;
	localparam int CYCLE_LIMIT = 400000;
	localparam string OPS = "|&*+-/!<>=";
	localparam string PUNCTS = "{}[]()?:;,.^";
	localparam string WORD_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string WORD_BODY = "aeEzAZ_019xq";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic full;
	logic empty;
	logic [CLASS_BITS-1:0] token_class;
	logic [OFFSET_BITS_DEF-1:0] token_start;
	logic [LENGTH_BITS_DEF-1:0] token_length;
	logic last_of_run;

	int mismatches;
	int outstanding;
	int tokens_checked;
	int longest_len;
	int bytes_sent = 0;
	int cycle_count = 0;
	bit calm = 1'b0;

	source_tokenizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .char_byte(char_byte),
		.empty(empty), .pop(pop),
		.token_class(token_class), .token_start(token_start),
		.token_length(token_length), .last_of_run(last_of_run)
	);

	tokenizer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .char_byte(char_byte),
		.empty(empty), .pop(pop),
		.token_class(token_class), .token_start(token_start),
		.token_length(token_length), .last_of_run(last_of_run),
		.mismatches(mismatches), .outstanding(outstanding),
		.tokens_checked(tokens_checked), .longest_len(longest_len)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hold push high across items unless an idle burst is drawn
	task automatic put_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		char_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_sep();
		case ($urandom_range(0, 5))
			0: put_byte(" ");
			1: put_byte(8'h09);
			2: put_byte(8'h0D);
			3: put_byte(8'h0A);
			default: ;
		endcase
	endtask

	task automatic put_digits();
		repeat ($urandom_range(1, 3))
			put_byte(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic put_word();
		put_byte(WORD_HEAD[$urandom_range(0, WORD_HEAD.len() - 1)]);
		repeat ($urandom_range(0, 5))
			put_byte(WORD_BODY[$urandom_range(0, WORD_BODY.len() - 1)]);
	endtask

	task automatic put_number();
		put_digits();
		if ($urandom_range(0, 2) == 0) begin
			put_byte(".");
			put_digits();
		end
		if ($urandom_range(0, 5) == 0) begin
			put_byte(".");
			put_digits();
		end
		if ($urandom_range(0, 2) == 0) begin
			put_byte($urandom_range(0, 1) ? "e" : "E");
			if ($urandom_range(0, 3) != 0) begin
				put_byte($urandom_range(0, 1) ? "+" : "-");
				put_digits();
				if ($urandom_range(0, 3) == 0) begin
					put_byte(".");
					put_digits();
					if ($urandom_range(0, 1))
						put_byte(".");
				end
			end else if ($urandom_range(0, 1)) begin
				put_byte(WORD_BODY[$urandom_range(0, WORD_BODY.len() - 1)]);
			end
		end
	endtask

	task automatic put_string(input bit terminated);
		logic [7:0] c;
		put_byte("\"");
		repeat ($urandom_range(0, 6)) begin
			do
				c = 8'($urandom_range(1, 255));
			while (c == "\"");
			put_byte(c);
		end
		put_byte(terminated ? 8'h22 : 8'h00);
	endtask

	task automatic put_operator();
		logic [7:0] c;
		c = OPS[$urandom_range(0, OPS.len() - 1)];
		put_byte(c);
		case ($urandom_range(0, 3))
			0: put_byte("=");
			1: put_byte(c);
			2: put_byte(WORD_BODY[$urandom_range(0, WORD_BODY.len() - 1)]);
			default: ;
		endcase
	endtask

	task automatic put_random_token();
		case ($urandom_range(0, 19))
			0, 1, 2: put_byte(PUNCTS[$urandom_range(0, PUNCTS.len() - 1)]);
			3, 4, 5, 6: put_operator();
			7, 8: put_string(1'b1);
			9, 10, 11: put_word();
			12, 13, 14: put_number();
			15: begin
				put_byte(".");
				put_digits();
			end
			16: put_byte(8'h00);
			17, 18: put_byte(8'($urandom_range(0, 255)));
			default: begin
				// broken sequences: open string or lone bar/ampersand cut by end
				if ($urandom_range(0, 1))
					put_string(1'b0);
				else begin
					put_byte($urandom_range(0, 1) ? "|" : "&");
					put_byte(8'h00);
				end
			end
		endcase
		put_sep();
	endtask

	// pop side: held high with random stall bursts until the calm tail
	initial begin
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d tokens still due", cycle_count,
			outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int random_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// doubled bar, lone ampersand, leading period, second period, signed exponent,
		// e without sign, open string cut by end, stray byte, ampersand at end
		put_text("||&x.5 1.2.3e+4 7e3\"ab");
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte("&");
		put_byte(8'h00);

		// every operator in its two-byte form, every punctuation mark
		for (int i = 0; i < OPS.len(); i++) begin
			put_byte(OPS[i]);
			put_byte((OPS[i] == "|" || OPS[i] == "&") ? OPS[i] : 8'h3D);
			put_sep();
		end
		for (int i = 0; i < PUNCTS.len(); i++) begin
			put_byte(PUNCTS[i]);
			put_byte(" ");
		end

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			if (bytes_sent - random_start > RANDOM_BYTES * 4 / 5)
				calm = 1'b1;
			put_random_token();
		end

		calm = 1'b1;
		put_byte(8'h00);
		push <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("sent %0d source bytes, checked %0d tokens, longest token %0d bytes",
			bytes_sent, tokens_checked, longest_len);
		$display("covered all operators, numbers, strings, words, end and broken input");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
